// ===== src/jipd_pkg.sv =====
// Shared types, constants, gain tables and cosine table builder for the impedance controller.
`default_nettype none

package jipd_pkg;

    localparam int JOINTS_DEF    = 7;
    localparam int COS_DEPTH_DEF = 1024;

    localparam int JOINT_W  = 3;
    localparam int POS_W    = 20;
    localparam int TRQ_W    = 19;
    localparam int PER_W    = 4;
    localparam int RUN_W    = 16;
    localparam int PSTEP_W  = 32;
    localparam int MSTEP_W  = 18;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int COEF_W   = 18;
    localparam int ERR_W    = 22;
    localparam int PROD_W   = ERR_W + COEF_W;
    localparam int FACT_W   = 17;

    localparam logic [RUN_W-1:0]   RUN_MS_RST     = 16'd20000;
    localparam logic [PSTEP_W-1:0] PHASE_STEP_RST = 32'd1073742;
    localparam logic [MSTEP_W-1:0] MAX_STEP_RST   = 18'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RUN_MS     = 2'd0,
        REG_PHASE_STEP = 2'd1,
        REG_MAX_STEP   = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_IDX,
        S_OFS,
        S_REF,
        S_KERR,
        S_FIN
    } state_t;

    typedef logic signed [COEF_W-1:0] coef_t;

    localparam coef_t STIFF_TAB [16] = '{
        18'sd600, 18'sd600, 18'sd600, 18'sd600, 18'sd250, 18'sd150, 18'sd50, 18'sd0,
        18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0
    };

    localparam coef_t DAMP_TAB [16] = '{
        18'sd50, 18'sd50, 18'sd50, 18'sd50, 18'sd30, 18'sd25, 18'sd15, 18'sd0,
        18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0
    };

    localparam coef_t OFFSET_TAB [16] = '{
        18'sd19661, -18'sd13107, 18'sd16384, -18'sd19661,
        18'sd13107, 18'sd9830, 18'sd13107, 18'sd0,
        18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0
    };

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    function automatic logic [63:0] cos_quarter(input logic [63:0] r);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] p;
        a = (r * HALF_PI_Q30) >> 30;
        a2 = (a * a) >> 30;
        term = Q30_ONE;
        p = ((a2 * term) >> 30) / 64'd132;
        term = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        p = ((a2 * term) >> 30) / 64'd90;
        term = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        p = ((a2 * term) >> 30) / 64'd56;
        term = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        p = ((a2 * term) >> 30) / 64'd30;
        term = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        p = ((a2 * term) >> 30) / 64'd12;
        term = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        p = ((a2 * term) >> 30) / 64'd2;
        term = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        return term;
    endfunction

    // 0.5*(1-cos) of a Q32 phase, Q1.16
    function automatic logic [FACT_W-1:0] cos_factor(input logic [63:0] t);
        logic [1:0]  q;
        logic [63:0] r;
        logic [63:0] mag;
        logic [63:0] f30;
        logic        neg;
        q = t[31:30];
        r = {34'd0, t[29:0]};
        mag = q[0] ? cos_quarter(Q30_ONE - r) : cos_quarter(r);
        neg = (q == 2'd1) || (q == 2'd2);
        f30 = neg ? ((Q30_ONE + mag) >> 1) : ((Q30_ONE - mag) >> 1);
        return FACT_W'((f30 + 64'd8192) >> 14);
    endfunction

endpackage

`default_nettype wire

// ===== src/joint_impedance_pd_rate_limited.sv =====
// Top level of the per-joint PD impedance controller with torque rate limiter.
`default_nettype none

// One transaction carries one joint of a control tick and yields one torque command.
// A transaction is accepted in the idle state; the accepting edge issues the start-position
// RAM read and, for joint 0, advances time and phase. The result then passes through the
// states S_IDX (cosine table read), S_OFS, S_REF and S_KERR (three passes through a single
// shared 22x18 multiplier: offset times factor, damping times velocity, stiffness times error)
// and S_FIN (round, rate-limit and saturate, then load). S_FIN holds for as long as an earlier
// result still waits unaccepted at the output register. A new transaction is taken while the
// previous result still waits at the output register. Start positions live in a RAM that is
// written on the first tick and needs no clearing pass after reset.
module joint_impedance_pd_rate_limited #(
    parameter int JOINTS          = jipd_pkg::JOINTS_DEF,
    parameter int COS_TABLE_DEPTH = jipd_pkg::COS_DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [jipd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [jipd_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [jipd_pkg::JOINT_W-1:0]         joint,
    input  wire logic signed [jipd_pkg::POS_W-1:0]    position,
    input  wire logic signed [jipd_pkg::POS_W-1:0]    velocity,
    input  wire logic signed [jipd_pkg::TRQ_W-1:0]    last_torque,
    input  wire logic [jipd_pkg::PER_W-1:0]           period_ms,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [jipd_pkg::JOINT_W-1:0]              joint_out,
    output logic signed [jipd_pkg::TRQ_W-1:0]         torque,
    output logic                                      finished
);

    localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int IW = (COS_TABLE_DEPTH > 1) ? $clog2(COS_TABLE_DEPTH) : 1;
    localparam int PW = jipd_pkg::POS_W;
    localparam int TW = jipd_pkg::TRQ_W;
    localparam int EW = jipd_pkg::ERR_W;
    localparam int MW = jipd_pkg::PROD_W;

    jipd_pkg::state_t state_reg, state_next;

    logic [jipd_pkg::RUN_W-1:0]   run_ms_reg;
    logic [jipd_pkg::PSTEP_W-1:0] phase_step_reg;
    logic [jipd_pkg::MSTEP_W-1:0] max_step_reg;

    logic [jipd_pkg::RUN_W-1:0]   elapsed_reg, elapsed_next;
    logic [jipd_pkg::PSTEP_W-1:0] phase_reg, phase_next;
    logic                         started_reg, started_next;

    logic [jipd_pkg::JOINT_W-1:0] joint_reg;
    logic signed [PW-1:0]         pos_reg;
    logic signed [PW-1:0]         vel_reg;
    logic signed [TW-1:0]         last_reg;
    logic                         inr_reg;
    logic                         cap_reg;
    logic signed [PW-1:0]         start_reg;
    logic                         fin_reg;
    logic signed [MW-1:0]         mul_reg;
    logic signed [MW-1:0]         dvel_reg;
    logic signed [EW-1:0]         err_reg;

    logic                         out_valid_reg;
    logic [jipd_pkg::JOINT_W-1:0] joint_out_reg;
    logic signed [TW-1:0]         torque_reg;
    logic                         finished_reg;

    logic                         in_acc;
    logic                         in_range;
    logic                         cap_now;
    logic                         ld_out;
    logic [16:0]                  elapsed_sum;
    logic [PW-1:0]                ram_rdata;
    logic [IW-1:0]                rom_addr;
    logic [63:0]                  idx_prod;
    logic [jipd_pkg::FACT_W-1:0]  rom_data;
    logic signed [EW-1:0]         mul_a;
    jipd_pkg::coef_t              mul_b;
    logic signed [MW-1:0]         mul_out;
    logic signed [MW-1:0]         adj_sum;
    logic signed [EW-1:0]         adj;
    logic signed [EW-1:0]         err_w;
    logic signed [MW:0]           diff;
    logic signed [MW:0]           diff_rnd;
    logic signed [MW-8:0]         rnd;
    logic signed [TW+1:0]         hi;
    logic signed [TW+1:0]         lo;
    logic signed [MW-8:0]         tau_c;
    logic signed [TW-1:0]         tau_w;

    assign in_acc   = in_valid && in_ready;
    assign in_range = {2'b00, joint} < 5'(JOINTS);
    assign cap_now  = in_acc && in_range && !started_reg;

    jipd_ram #(
        .WIDTH(PW),
        .DEPTH(JOINTS),
        .AW   (AW)
    ) u_start_ram (
        .clk  (clk),
        .we   (cap_now),
        .waddr(AW'(joint)),
        .wdata(position),
        .raddr(AW'(joint)),
        .rdata(ram_rdata)
    );

    assign idx_prod = 64'(phase_reg) * 64'(COS_TABLE_DEPTH);
    assign rom_addr = idx_prod[32 +: IW];

    jipd_cos_rom #(
        .DEPTH(COS_TABLE_DEPTH),
        .AW   (IW)
    ) u_cos_rom (
        .clk (clk),
        .addr(rom_addr),
        .data(rom_data)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_ms_reg     <= jipd_pkg::RUN_MS_RST;
            phase_step_reg <= jipd_pkg::PHASE_STEP_RST;
            max_step_reg   <= jipd_pkg::MAX_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                jipd_pkg::REG_RUN_MS:     run_ms_reg     <= cfg_data[jipd_pkg::RUN_W-1:0];
                jipd_pkg::REG_PHASE_STEP: phase_step_reg <= cfg_data[jipd_pkg::PSTEP_W-1:0];
                jipd_pkg::REG_MAX_STEP:   max_step_reg   <= cfg_data[jipd_pkg::MSTEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Tick time, phase and start capture
    assign elapsed_sum = 17'(elapsed_reg) + 17'(period_ms);

    always_comb
    begin
        elapsed_next = elapsed_reg;
        phase_next   = phase_reg;
        started_next = started_reg;
        if (in_acc && (joint == '0))
        begin
            elapsed_next = elapsed_sum[16] ? '1 : elapsed_sum[15:0];
            phase_next   = phase_reg + 32'(phase_step_reg * 32'(period_ms));
        end
        if (cap_now && ({2'b00, joint} == 5'(JOINTS - 1)))
        begin
            started_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jipd_pkg::S_IDLE;
            elapsed_reg   <= '0;
            phase_reg     <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            elapsed_reg   <= elapsed_next;
            phase_reg     <= phase_next;
            started_reg   <= started_next;
            out_valid_reg <= ld_out || (out_valid_reg && !out_ready);
        end
    end

    // Sequencer and shared multiplier operand selection
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ld_out     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            jipd_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = jipd_pkg::S_IDX;
                end
            end
            jipd_pkg::S_IDX:
            begin
                state_next = jipd_pkg::S_OFS;
            end
            jipd_pkg::S_OFS:
            begin
                mul_a      = EW'($signed({1'b0, rom_data}));
                mul_b      = jipd_pkg::OFFSET_TAB[{1'b0, joint_reg}];
                state_next = jipd_pkg::S_REF;
            end
            jipd_pkg::S_REF:
            begin
                mul_a      = EW'(vel_reg);
                mul_b      = jipd_pkg::DAMP_TAB[{1'b0, joint_reg}];
                state_next = jipd_pkg::S_KERR;
            end
            jipd_pkg::S_KERR:
            begin
                mul_a      = err_reg;
                mul_b      = jipd_pkg::STIFF_TAB[{1'b0, joint_reg}];
                state_next = jipd_pkg::S_FIN;
            end
            jipd_pkg::S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ld_out     = 1'b1;
                    state_next = jipd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = jipd_pkg::S_IDLE;
            end
        endcase
    end

    assign mul_out = MW'(mul_a) * MW'(mul_b);

    // Reference and error
    assign adj_sum = mul_reg + MW'(32768);
    assign adj     = fin_reg ? '0 : EW'(adj_sum >>> 16);
    assign err_w   = EW'(start_reg) + adj - EW'(pos_reg);

    // Round, rate-limit and saturate
    assign diff     = (MW + 1)'(mul_reg) - (MW + 1)'(dvel_reg);
    assign diff_rnd = diff + (MW + 1)'(128);
    assign rnd      = diff_rnd[MW:8];
    assign hi       = (TW + 2)'(last_reg) + (TW + 2)'($signed({1'b0, max_step_reg}));
    assign lo       = (TW + 2)'(last_reg) - (TW + 2)'($signed({1'b0, max_step_reg}));

    always_comb
    begin
        tau_c = rnd;
        if (tau_c > (MW - 7)'(hi))
        begin
            tau_c = (MW - 7)'(hi);
        end
        if (tau_c < (MW - 7)'(lo))
        begin
            tau_c = (MW - 7)'(lo);
        end
        if (tau_c > (MW - 7)'($signed({1'b0, {(TW - 1){1'b1}}})))
        begin
            tau_w = {1'b0, {(TW - 1){1'b1}}};
        end
        else if (tau_c < (MW - 7)'($signed({1'b1, {(TW - 1){1'b0}}})))
        begin
            tau_w = {1'b1, {(TW - 1){1'b0}}};
        end
        else
        begin
            tau_w = TW'(tau_c);
        end
        if (!inr_reg)
        begin
            tau_w = '0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            joint_reg <= joint;
            pos_reg   <= position;
            vel_reg   <= velocity;
            last_reg  <= last_torque;
            inr_reg   <= in_range;
            cap_reg   <= cap_now;
        end
        case (state_reg)
            jipd_pkg::S_IDX:
            begin
                start_reg <= cap_reg ? pos_reg : $signed(ram_rdata);
                fin_reg   <= elapsed_reg >= run_ms_reg;
            end
            jipd_pkg::S_OFS:
            begin
                mul_reg <= mul_out;
            end
            jipd_pkg::S_REF:
            begin
                err_reg  <= err_w;
                dvel_reg <= mul_out;
            end
            jipd_pkg::S_KERR:
            begin
                mul_reg <= mul_out;
            end
            default: ;
        endcase
        if (ld_out)
        begin
            joint_out_reg <= joint_reg;
            torque_reg    <= tau_w;
            finished_reg  <= fin_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign joint_out = joint_out_reg;
    assign torque    = torque_reg;
    assign finished  = finished_reg;

endmodule

`default_nettype wire

// ===== src/jipd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module jipd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 7,
    parameter int AW    = 3
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/jipd_cos_rom.sv =====
// Raised-cosine factor table with registered read, contents built at elaboration.
`default_nettype none

module jipd_cos_rom #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                         clk,
    input  wire logic [AW-1:0]                addr,
    output logic      [jipd_pkg::FACT_W-1:0]  data
);

    logic [jipd_pkg::FACT_W-1:0] tab_w [DEPTH];
    logic [jipd_pkg::FACT_W-1:0] data_reg;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_ent
        localparam logic [63:0] PH = (64'(k) << 32) / DEPTH;
        assign tab_w[k] = jipd_pkg::cos_factor(PH);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= tab_w[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== src/jipd_checker.sv =====
// Port-level checks for the impedance controller and their binding to the top level.
`default_nettype none

module jipd_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               cfg_we,
    input wire logic [jipd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input wire logic [jipd_pkg::CFG_W-1:0]         cfg_data,
    input wire logic                               in_valid,
    input wire logic                               in_ready,
    input wire logic [jipd_pkg::JOINT_W-1:0]       joint,
    input wire logic signed [jipd_pkg::POS_W-1:0]  position,
    input wire logic signed [jipd_pkg::POS_W-1:0]  velocity,
    input wire logic signed [jipd_pkg::TRQ_W-1:0]  last_torque,
    input wire logic [jipd_pkg::PER_W-1:0]         period_ms,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic [jipd_pkg::JOINT_W-1:0]       joint_out,
    input wire logic signed [jipd_pkg::TRQ_W-1:0]  torque,
    input wire logic                               finished
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(torque) && $stable(joint_out)
            && $stable(finished))
        else $error("stalled result changed");

    // One transaction in flight: drop ready after acceptance
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready held after input transaction");

    // A new result only follows work on an accepted item
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while idle");

endmodule

bind joint_impedance_pd_rate_limited jipd_checker u_jipd_checker (.*);

`default_nettype wire
